// ===== src/rrbc_pkg.sv =====
`default_nettype none

package rrbc_pkg;

    // relay set and limit coding
    localparam int NUM_RELAYS       = 4;
    localparam int RIDX_W           = (NUM_RELAYS > 1) ? $clog2(NUM_RELAYS) : 1;
    localparam int UNLIMITED_CODE   = 255;
    localparam int SUPPRESSED_RELAY = 1;
    localparam int DUE_W            = 4;

    // field widths
    localparam int OP_W      = 2;
    localparam int RELAY_W   = 4;
    localparam int LIMIT_W   = 8;
    localparam int COUNT_W   = 8;
    localparam int BACKOFF_W = 16;

    localparam logic [BACKOFF_W-1:0] BACKOFF_RESET = BACKOFF_W'(100);

    // operation codes
    localparam logic [OP_W-1:0] OP_RETRY     = 2'd0;
    localparam logic [OP_W-1:0] OP_SET_LIMIT = 2'd1;
    localparam logic [OP_W-1:0] OP_FAIL_FAST = 2'd2;
    localparam logic [OP_W-1:0] OP_TICK      = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [RELAY_W-1:0] relay_index;
        logic [LIMIT_W-1:0] retry_limit;
    } req_t;

    typedef struct packed {
        logic               status;
        logic               retry_scheduled;
        logic               relay_error;
        logic [RELAY_W-1:0] error_relay;
        logic [DUE_W-1:0]   retry_due_mask;
    } res_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic exec;
    } cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

endpackage

`default_nettype wire

// ===== src/rrbc_ctrl.sv =====
`default_nettype none

module rrbc_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output rrbc_pkg::cmd_t     cmd,
    output logic               busy,
    output logic               done
);

    rrbc_pkg::state_t state_reg;
    rrbc_pkg::state_t state_next;
    logic             done_reg;
    logic             done_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rrbc_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = rrbc_pkg::ST_EXEC;
                end
            end
            rrbc_pkg::ST_EXEC:
            begin
                state_next = rrbc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = rrbc_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd.load  = 1'b0;
        cmd.exec  = 1'b0;
        busy      = 1'b0;
        done_next = 1'b0;
        unique case (state_reg)
            rrbc_pkg::ST_IDLE:
            begin
                cmd.load = start;
            end
            rrbc_pkg::ST_EXEC:
            begin
                cmd.exec  = 1'b1;
                busy      = 1'b1;
                done_next = 1'b1;
            end
            default:
            begin
                cmd.load = 1'b0;
            end
        endcase
    end

    // state and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rrbc_pkg::ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign done = done_reg;

endmodule

`default_nettype wire

// ===== src/rrbc_datapath.sv =====
`default_nettype none

module rrbc_datapath (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire rrbc_pkg::cmd_t                   cmd,
    input  wire rrbc_pkg::req_t                   request,
    input  wire logic                             cfg_we,
    input  wire logic [rrbc_pkg::BACKOFF_W-1:0]   cfg_wdata,
    output rrbc_pkg::res_t                        result
);

    rrbc_pkg::req_t                      req_reg;
    rrbc_pkg::res_t                      result_reg;
    rrbc_pkg::res_t                      result_next;
    logic [rrbc_pkg::BACKOFF_W-1:0]      backoff_reg;
    logic [rrbc_pkg::LIMIT_W-1:0]        limit_reg;
    logic [rrbc_pkg::LIMIT_W-1:0]        limit_next;
    logic [rrbc_pkg::COUNT_W-1:0]        count_reg [rrbc_pkg::NUM_RELAYS];
    logic [rrbc_pkg::COUNT_W-1:0]        count_next [rrbc_pkg::NUM_RELAYS];
    logic [rrbc_pkg::BACKOFF_W-1:0]      left_reg [rrbc_pkg::NUM_RELAYS];
    logic [rrbc_pkg::BACKOFF_W-1:0]      left_next [rrbc_pkg::NUM_RELAYS];
    logic [rrbc_pkg::NUM_RELAYS-1:0]     running_reg;
    logic [rrbc_pkg::NUM_RELAYS-1:0]     running_next;
    logic [rrbc_pkg::NUM_RELAYS-1:0]     expire;
    logic [rrbc_pkg::RIDX_W-1:0]         sel;
    logic                                relay_ok;
    logic                                unlimited;
    logic                                exhausted;
    logic                                suppressed;

    // decode of the held request
    assign sel        = req_reg.relay_index[rrbc_pkg::RIDX_W-1:0];
    assign relay_ok   = {1'b0, req_reg.relay_index}
                        < (rrbc_pkg::RELAY_W+1)'(rrbc_pkg::NUM_RELAYS);
    assign unlimited  = limit_reg == rrbc_pkg::LIMIT_W'(rrbc_pkg::UNLIMITED_CODE);
    assign exhausted  = !unlimited && (count_reg[sel] >= limit_reg);
    assign suppressed = req_reg.relay_index
                        == rrbc_pkg::RELAY_W'(rrbc_pkg::SUPPRESSED_RELAY);

    // operation execution
    always_comb
    begin
        limit_next   = limit_reg;
        count_next   = count_reg;
        left_next    = left_reg;
        running_next = running_reg;
        expire       = '0;
        result_next  = '0;
        unique case (req_reg.operation)
            rrbc_pkg::OP_RETRY:
            begin
                if (!relay_ok)
                begin
                    result_next.status = 1'b1;
                end
                else if (exhausted)
                begin
                    if (!suppressed)
                    begin
                        result_next.relay_error = 1'b1;
                        result_next.error_relay = req_reg.relay_index;
                    end
                end
                else
                begin
                    if (!unlimited)
                    begin
                        count_next[sel] = rrbc_pkg::COUNT_W'(count_reg[sel] + 1'b1);
                    end
                    left_next[sel]              = backoff_reg;
                    running_next[sel]           = 1'b1;
                    result_next.retry_scheduled = 1'b1;
                end
            end
            rrbc_pkg::OP_SET_LIMIT:
            begin
                if ({1'b0, req_reg.retry_limit}
                    > (rrbc_pkg::LIMIT_W+1)'(rrbc_pkg::UNLIMITED_CODE))
                begin
                    result_next.status = 1'b1;
                end
                else
                begin
                    limit_next   = req_reg.retry_limit;
                    running_next = '0;
                    for (int i = 0; i < rrbc_pkg::NUM_RELAYS; i++)
                    begin
                        count_next[i] = '0;
                        left_next[i]  = '0;
                    end
                end
            end
            rrbc_pkg::OP_FAIL_FAST:
            begin
                limit_next   = '0;
                running_next = '0;
                for (int i = 0; i < rrbc_pkg::NUM_RELAYS; i++)
                begin
                    left_next[i] = '0;
                end
            end
            rrbc_pkg::OP_TICK:
            begin
                // every running timer counts down, expired ones stop
                for (int i = 0; i < rrbc_pkg::NUM_RELAYS; i++)
                begin
                    if (running_reg[i])
                    begin
                        if (left_reg[i] <= rrbc_pkg::BACKOFF_W'(1))
                        begin
                            left_next[i]    = '0;
                            running_next[i] = 1'b0;
                            expire[i]       = 1'b1;
                        end
                        else
                        begin
                            left_next[i] = rrbc_pkg::BACKOFF_W'(left_reg[i] - 1'b1);
                        end
                    end
                end
                result_next.retry_due_mask = rrbc_pkg::DUE_W'(expire);
            end
            default:
            begin
                result_next = '0;
            end
        endcase
    end

    // relay state and backoff register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            backoff_reg <= rrbc_pkg::BACKOFF_RESET;
            limit_reg   <= '0;
            running_reg <= '0;
            for (int i = 0; i < rrbc_pkg::NUM_RELAYS; i++)
            begin
                count_reg[i] <= '0;
                left_reg[i]  <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                backoff_reg <= cfg_wdata;
            end
            if (cmd.exec)
            begin
                limit_reg   <= limit_next;
                running_reg <= running_next;
                count_reg   <= count_next;
                left_reg    <= left_next;
            end
        end
    end

    // request capture and result register
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= request;
        end
        if (cmd.exec)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

// ===== src/relay_retry_backoff_controller.sv =====
`default_nettype none

// A request is taken on a clock edge with start high and busy low; the block
// then stays busy while it updates the per-relay counts and timers, and the
// result appears with done high for exactly one cycle in the cycle after
// that. Start is ignored while busy, so a new request waits for busy low. The
// receiver cannot stall: result must be captured while done is high. Every
// request, ticks included, gives exactly one result. cfg_we/cfg_wdata load
// the backoff delay (reset value 100 ticks) and should only be used while
// no request is in flight.
module relay_retry_backoff_controller (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire rrbc_pkg::req_t                  request,
    output logic                                 busy,
    output logic                                 done,
    output rrbc_pkg::res_t                       result,
    input  wire logic                            cfg_we,
    input  wire logic [rrbc_pkg::BACKOFF_W-1:0]  cfg_wdata
);

    rrbc_pkg::cmd_t cmd;

    // sequencing
    rrbc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // relay state and result
    rrbc_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .request   (request),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .result    (result)
    );

    // accepted request always goes busy next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> busy)
        else $error("accepted request did not start execution");

    // every execute cycle is followed by exactly one result strobe
    a_exec_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> (done && !busy))
        else $error("execution not followed by a result");

    // a strobe only follows an execute cycle
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(cmd.exec))
        else $error("result strobe without execution");

    // an error never comes with a schedule or a status flag and never names the suppressed relay
    a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.relay_error) |->
        (!result.retry_scheduled && !result.status
         && result.error_relay != rrbc_pkg::RELAY_W'(rrbc_pkg::SUPPRESSED_RELAY)))
        else $error("malformed relay error result");

endmodule

`default_nettype wire
